// File: rtl/tcgw_pkg.sv
// Package for the text console glyph writer: shared types and fixed constants.
// Used by the front, the back and the top level; depends on nothing.
`timescale 1ns / 1ps

package tcgw_pkg;

   localparam int GLYPH_WIDTH = 8;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   localparam logic [11:0] SCREEN_WIDTH_RESET = 12'd640;
   localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;

   localparam logic [1:0] CSR_SCREEN_WIDTH = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ENABLED = 2'd2;

   typedef enum logic {
      OP_WRITE_CHAR = 1'b0,
      OP_LOAD_ROW = 1'b1
   } op_type;

   typedef enum logic {
      KIND_GLYPH_ROW = 1'b0,
      KIND_SCROLL = 1'b1
   } kind_type;

   typedef enum logic {
      ST_ROWS,
      ST_SCROLL
   } back_state_type;

   // One classified word passed from the front to the back.
   typedef struct packed {
      logic load;
      logic draw;
      logic scroll;
      logic [7:0] code;
      logic [3:0] grow;
      logic [7:0] gbits;
      logic [11:0] x;
      logic [11:0] y;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0] mask;
      logic last;
   } result_type;

endpackage

// File: rtl/tcgw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the font store; no dependencies.
`timescale 1ns / 1ps

module tcgw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tcgw_fifo.sv
// Small register queue with occupancy count, used between front and back and
// for finished results. No dependencies.
`timescale 1ns / 1ps

module tcgw_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [WIDTH-1:0] wdata,
   output logic full,
   input  logic pop,
   output logic [WIDTH-1:0] rdata,
   output logic empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign count = count_ff;
   assign rdata = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/tcgw_front.sv
// Front end: configuration registers, cursor tracking and classification of
// each accepted word into a back-end command. Depends on tcgw_pkg.
`timescale 1ns / 1ps

module tcgw_front #(
   parameter int GLYPH_COUNT = 256,
   parameter int GLYPH_HEIGHT = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_operation,
   input  logic [7:0] req_char_code,
   input  logic [3:0] req_glyph_row,
   input  logic [7:0] req_glyph_bits,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [11:0] csr_data,
   output logic cmd_push,
   output tcgw_pkg::cmd_type cmd_data,
   input  logic cmd_full
);

   import tcgw_pkg::*;

   logic [11:0] width_ff, height_ff;
   logic enabled_ff;
   logic [11:0] col_ff, col_in;
   logic [11:0] row_ff, row_in;

   logic accept;
   logic [11:0] col_eff, row_eff;
   logic [12:0] col_sum;
   logic [13:0] row_sum, row_chk;
   logic is_newline, wrap, line_scroll;
   logic load_ok;

   assign csr_ready = 1'b1;
   assign req_full = cmd_full;
   assign accept = req_push && !cmd_full;

   // A cursor left below the screen (height lowered) restarts at the origin.
   assign row_eff = (row_ff >= height_ff) ? '0 : row_ff;
   assign col_eff = (row_ff >= height_ff) ? '0 : col_ff;

   assign is_newline = (req_char_code == NEWLINE_CODE);
   assign col_sum = {1'b0, col_eff} + 13'(GLYPH_WIDTH);
   assign wrap = is_newline || (col_sum >= {1'b0, width_ff});
   assign row_sum = {2'b00, row_eff} + 14'(GLYPH_HEIGHT);
   assign row_chk = row_sum + 14'(GLYPH_HEIGHT);
   assign line_scroll = wrap && (row_chk >= {2'b00, height_ff});

   assign load_ok = ({1'b0, req_char_code} < 9'(GLYPH_COUNT))
                    && (6'(req_glyph_row) < 6'(GLYPH_HEIGHT));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept && (op_type'(req_operation) == OP_WRITE_CHAR) && enabled_ff) begin
         if (wrap) begin
            col_in = '0;
            row_in = line_scroll ? row_eff : row_sum[11:0];
         end else begin
            col_in = col_sum[11:0];
            row_in = row_eff;
         end
      end
   end

   // A newline that stays on the screen only moves the cursor, so the back end
   // never sees it.
   always_comb begin
      cmd_data.load = (op_type'(req_operation) == OP_LOAD_ROW);
      cmd_data.draw = (op_type'(req_operation) == OP_WRITE_CHAR) && !is_newline;
      cmd_data.scroll = (op_type'(req_operation) == OP_WRITE_CHAR) && line_scroll;
      cmd_data.code = req_char_code;
      cmd_data.grow = req_glyph_row;
      cmd_data.gbits = req_glyph_bits;
      cmd_data.x = col_eff;
      cmd_data.y = row_eff;
      unique case (op_type'(req_operation))
         OP_LOAD_ROW: cmd_push = accept && load_ok;
         OP_WRITE_CHAR: cmd_push = accept && enabled_ff && (!is_newline || line_scroll);
         default: cmd_push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= SCREEN_WIDTH_RESET;
         height_ff <= SCREEN_HEIGHT_RESET;
         enabled_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_valid) begin
            if (csr_index == CSR_SCREEN_WIDTH) begin
               width_ff <= csr_data;
            end else if (csr_index == CSR_SCREEN_HEIGHT) begin
               height_ff <= csr_data;
            end else if (csr_index == CSR_ENABLED) begin
               enabled_ff <= csr_data[0];
            end
         end
      end
   end

endmodule

// File: rtl/tcgw_back.sv
// Back end: carries out queued commands, writing font rows into the font RAM
// and streaming glyph rows and scroll words. Depends on tcgw_pkg, tcgw_ram.
`timescale 1ns / 1ps

module tcgw_back #(
   parameter int GLYPH_COUNT = 256,
   parameter int GLYPH_HEIGHT = 16,
   parameter int RES_DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  tcgw_pkg::cmd_type cmd_data,
   input  logic cmd_empty,
   output logic cmd_pop,
   input  logic [$clog2(RES_DEPTH+1)-1:0] res_count,
   output logic res_push,
   output tcgw_pkg::result_type res_data
);

   import tcgw_pkg::*;

   localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int AW = $clog2(DEPTH);
   localparam int RW = $clog2(GLYPH_HEIGHT);
   localparam int CW = $clog2(RES_DEPTH + 1);

   back_state_type state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   result_type meta_ff, meta_in;
   logic meta_valid_ff, meta_valid_in;
   logic blank_ff, blank_in;

   logic space, row_final, blank;
   logic ram_we;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0] rd_data;

   // Room is counted against words already on their way through the RAM read.
   assign space = (({1'b0, res_count} + (CW + 1)'(meta_valid_ff))
                   < (CW + 1)'(RES_DEPTH));
   assign row_final = (row_ff == RW'(GLYPH_HEIGHT - 1));
   assign blank = ({1'b0, cmd_data.code} >= 9'(GLYPH_COUNT));

   assign wr_addr = AW'(cmd_data.code) * AW'(GLYPH_HEIGHT) + AW'(cmd_data.grow);
   assign rd_addr = blank ? '0
                    : AW'(cmd_data.code) * AW'(GLYPH_HEIGHT) + AW'(row_ff);

   tcgw_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_font_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(wr_addr),
      .wr_data(cmd_data.gbits),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ROWS: begin
            if (!cmd_empty && !cmd_data.load && cmd_data.draw && space && row_final
                && cmd_data.scroll) begin
               state_in = ST_SCROLL;
            end
         end
         ST_SCROLL: begin
            if (space) begin
               state_in = ST_ROWS;
            end
         end
         default: state_in = ST_ROWS;
      endcase
   end

   always_comb begin
      cmd_pop = 1'b0;
      ram_we = 1'b0;
      row_in = row_ff;
      meta_valid_in = 1'b0;
      blank_in = blank_ff;
      meta_in = meta_ff;
      unique case (state_ff)
         ST_ROWS: begin
            if (!cmd_empty) begin
               priority if (cmd_data.load) begin
                  ram_we = 1'b1;
                  cmd_pop = 1'b1;
               end else if (cmd_data.draw) begin
                  if (space) begin
                     meta_valid_in = 1'b1;
                     blank_in = blank;
                     meta_in.kind = KIND_GLYPH_ROW;
                     meta_in.x = cmd_data.x;
                     meta_in.y = cmd_data.y + 12'(row_ff);
                     meta_in.mask = '0;
                     meta_in.last = row_final && !cmd_data.scroll;
                     if (row_final) begin
                        row_in = '0;
                        cmd_pop = !cmd_data.scroll;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
               end else begin
                  // Newline that needs a scroll: a single scroll word.
                  if (space) begin
                     meta_valid_in = 1'b1;
                     blank_in = 1'b1;
                     meta_in.kind = KIND_SCROLL;
                     meta_in.x = '0;
                     meta_in.y = '0;
                     meta_in.mask = '0;
                     meta_in.last = 1'b1;
                     cmd_pop = 1'b1;
                  end
               end
            end
         end
         ST_SCROLL: begin
            if (space) begin
               meta_valid_in = 1'b1;
               blank_in = 1'b1;
               meta_in.kind = KIND_SCROLL;
               meta_in.x = '0;
               meta_in.y = '0;
               meta_in.mask = '0;
               meta_in.last = 1'b1;
               cmd_pop = 1'b1;
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      res_push = meta_valid_ff;
      res_data = meta_ff;
      res_data.mask = blank_ff ? '0 : rd_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ROWS;
         row_ff <= '0;
         meta_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         meta_valid_ff <= meta_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff <= meta_in;
      blank_ff <= blank_in;
   end

   // A glyph in progress keeps its drawing command at the queue head.
   a_row_needs_draw: assert property (@(posedge clock) disable iff (reset)
      (row_ff != '0) |-> (!cmd_empty && cmd_data.draw && !cmd_data.load))
      else $error("row counter running without a drawing command");

   a_scroll_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCROLL) |-> (!cmd_empty && cmd_data.scroll && cmd_data.draw))
      else $error("scroll pending without a scrolling command");

   a_pop_after_glyph: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd_data.draw) |-> (state_ff == ST_SCROLL || row_final))
      else $error("drawing command released before its last row");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      meta_valid_ff |-> (res_count < CW'(RES_DEPTH)))
      else $error("result queue overrun");

endmodule

// File: rtl/text_console_glyph_writer.sv
// Text console glyph writer: 8-pixel-wide text console cursor engine.
// Top level; depends on tcgw_pkg, tcgw_front, tcgw_back, tcgw_fifo.
//
// Input words (req_*) are pushed while req_full is low. A write-character word
// produces one glyph-row result per font row (GLYPH_HEIGHT of them) and, when
// the line break reaches the bottom, a scroll result; a newline produces at
// most the scroll result; a font-load word writes one font row and produces
// nothing. Character writes are dropped while the enabled register is clear.
// Results are read like a queue: a result sits on rsp_* while rsp_empty is low
// and leaves on rsp_pop. rsp_last marks the last result of a word.
// Registers are written through csr_* (index 0 width, 1 height, 2 enabled);
// write them only while the block is idle. csr_ready is always high.
// A word passes through the command queue, the back end's result register and
// the result queue before its first row is on the result ports. Throughput:
// one result per cycle from the font RAM read port while the result queue
// has room. A four-entry command queue lets the front accept words while the
// back is still drawing.
// Reset clears the cursor and queues and restores the register defaults; the
// font RAM is not cleared and must be loaded before use. A stalled reader
// fills the result queue, then the command queue, then raises req_full.
`timescale 1ns / 1ps

module text_console_glyph_writer #(
   parameter int GLYPH_COUNT = 256,
   parameter int GLYPH_HEIGHT = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic req_operation,
   input  logic [7:0] req_char_code,
   input  logic [3:0] req_glyph_row,
   input  logic [7:0] req_glyph_bits,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic rsp_kind,
   output logic [11:0] rsp_pixel_x,
   output logic [11:0] rsp_pixel_y,
   output logic [7:0] rsp_row_mask,
   output logic rsp_last,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [11:0] csr_data
);

   import tcgw_pkg::*;

   localparam int CMD_DEPTH = 4;
   localparam int RES_DEPTH = 4;

   cmd_type cmd_wdata, cmd_rdata;
   logic cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
   logic [$bits(cmd_type)-1:0] cmd_rbits;

   result_type res_wdata, res_rdata;
   logic res_push, res_full;
   logic [$clog2(RES_DEPTH+1)-1:0] res_count;
   logic [$bits(result_type)-1:0] res_rbits;

   tcgw_front #(
      .GLYPH_COUNT(GLYPH_COUNT),
      .GLYPH_HEIGHT(GLYPH_HEIGHT)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_operation(req_operation),
      .req_char_code(req_char_code),
      .req_glyph_row(req_glyph_row),
      .req_glyph_bits(req_glyph_bits),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cmd_push(cmd_push),
      .cmd_data(cmd_wdata),
      .cmd_full(cmd_full)
   );

   tcgw_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .wdata(cmd_wdata),
      .full(cmd_full),
      .pop(cmd_pop),
      .rdata(cmd_rbits),
      .empty(cmd_empty),
      .count(cmd_count)
   );

   assign cmd_rdata = cmd_type'(cmd_rbits);

   tcgw_back #(
      .GLYPH_COUNT(GLYPH_COUNT),
      .GLYPH_HEIGHT(GLYPH_HEIGHT),
      .RES_DEPTH(RES_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_data(cmd_rdata),
      .cmd_empty(cmd_empty),
      .cmd_pop(cmd_pop),
      .res_count(res_count),
      .res_push(res_push),
      .res_data(res_wdata)
   );

   tcgw_fifo #(
      .WIDTH($bits(result_type)),
      .DEPTH(RES_DEPTH)
   ) u_res_fifo (
      .clock(clock),
      .reset(reset),
      .push(res_push),
      .wdata(res_wdata),
      .full(res_full),
      .pop(rsp_pop),
      .rdata(res_rbits),
      .empty(rsp_empty),
      .count(res_count)
   );

   assign res_rdata = result_type'(res_rbits);
   assign rsp_kind = res_rdata.kind;
   assign rsp_pixel_x = res_rdata.x;
   assign rsp_pixel_y = res_rdata.y;
   assign rsp_row_mask = res_rdata.mask;
   assign rsp_last = res_rdata.last;

   // The back end counts its own room, so the result queue never refuses a word.
   a_res_no_drop: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result word offered to a full queue");

   a_cmd_count: assert property (@(posedge clock) disable iff (reset)
      (cmd_count == '0) == cmd_empty)
      else $error("command queue count and empty flag disagree");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      req_full |-> (cmd_count == ($clog2(CMD_DEPTH+1))'(CMD_DEPTH)))
      else $error("input stalled while the command queue has room");

endmodule

// File: tb/tcgw_result_checker.sv
// Result checker for the text console glyph writer: watches the request, result and
// register channels, predicts every result word and compares it with what the block pops.
// Depends on tcgw_pkg for the operation, result-kind and register-index codes.
`timescale 1ns / 1ps

module tcgw_result_checker
   import tcgw_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   input  logic req_full,
   input  logic req_operation,
   input  logic [7:0] req_char_code,
   input  logic [3:0] req_glyph_row,
   input  logic [7:0] req_glyph_bits,
   input  logic rsp_empty,
   input  logic rsp_pop,
   input  logic rsp_kind,
   input  logic [11:0] rsp_pixel_x,
   input  logic [11:0] rsp_pixel_y,
   input  logic [7:0] rsp_row_mask,
   input  logic rsp_last,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [11:0] csr_data,
   output int mismatch_count,
   output int rows_outstanding
);

   localparam int ROWS_PER_GLYPH = 16;

   logic [7:0] font_copy [0:4095];
   logic [11:0] width_reg;
   logic [11:0] height_reg;
   logic enable_reg;
   logic [11:0] col_pos;
   logic [11:0] row_pos;
   result_type rows_due [$];
   int fail_count = 0;
   int due_count = 0;

   assign mismatch_count = fail_count;
   assign rows_outstanding = due_count;

   // Moves the cursor to the start of the next text line and says whether the
   // screen has to scroll instead.
   function automatic logic advance_line();
      int unsigned next_row;
      next_row = int'(row_pos) + ROWS_PER_GLYPH;
      col_pos = '0;
      if (next_row + ROWS_PER_GLYPH >= int'(height_reg)) begin
         row_pos = 12'(next_row - ROWS_PER_GLYPH);
         return 1'b1;
      end
      row_pos = 12'(next_row);
      return 1'b0;
   endfunction

   task automatic predict_word(input logic op, input logic [7:0] code,
                               input logic [3:0] grow, input logic [7:0] gbits);
      logic [11:0] old_col;
      logic [11:0] old_row;
      logic draw;
      logic scroll;
      result_type entry;
      if (op == OP_LOAD_ROW) begin
         font_copy[{code, grow}] = gbits;
         return;
      end
      if (!enable_reg) return;
      if (row_pos >= height_reg) begin
         col_pos = '0;
         row_pos = '0;
      end
      old_col = col_pos;
      old_row = row_pos;
      draw = (code != NEWLINE_CODE);
      if (!draw) begin
         scroll = advance_line();
      end else if (int'(old_col) + GLYPH_WIDTH >= int'(width_reg)) begin
         scroll = advance_line();
      end else begin
         col_pos = old_col + 12'(GLYPH_WIDTH);
         scroll = 1'b0;
      end
      if (draw) begin
         for (int r = 0; r < ROWS_PER_GLYPH; r++) begin
            entry.kind = KIND_GLYPH_ROW;
            entry.x = old_col;
            entry.y = old_row + 12'(r);
            entry.mask = font_copy[{code, 4'(r)}];
            entry.last = (r == ROWS_PER_GLYPH - 1) && !scroll;
            rows_due.push_back(entry);
         end
      end
      if (scroll) begin
         entry.kind = KIND_SCROLL;
         entry.x = '0;
         entry.y = '0;
         entry.mask = '0;
         entry.last = 1'b1;
         rows_due.push_back(entry);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         width_reg = SCREEN_WIDTH_RESET;
         height_reg = SCREEN_HEIGHT_RESET;
         enable_reg = 1'b0;
         col_pos = '0;
         row_pos = '0;
         rows_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SCREEN_WIDTH: width_reg = csr_data;
               CSR_SCREEN_HEIGHT: height_reg = csr_data;
               CSR_ENABLED: enable_reg = csr_data[0];
               default: ;
            endcase
         end
         // A word popped at this edge cannot stem from a word pushed at it.
         if (rsp_pop && !rsp_empty) begin
            if (rows_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word: kind %0d x %0d y %0d mask %02h last %0d",
                           rsp_kind, rsp_pixel_x, rsp_pixel_y, rsp_row_mask, rsp_last);
            end else begin
               want = rows_due.pop_front();
               if (want.kind != kind_type'(rsp_kind) || want.x != rsp_pixel_x ||
                   want.y != rsp_pixel_y || want.mask != rsp_row_mask ||
                   want.last != rsp_last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"result word mismatch: expected kind %0d x %0d y %0d mask %02h",
                               " last %0d, got kind %0d x %0d y %0d mask %02h last %0d"},
                              want.kind, want.x, want.y, want.mask, want.last,
                              rsp_kind, rsp_pixel_x, rsp_pixel_y, rsp_row_mask, rsp_last);
               end
            end
         end
         if (req_push && !req_full)
            predict_word(req_operation, req_char_code, req_glyph_row, req_glyph_bits);
      end
      due_count = rows_due.size();
   end

endmodule

// File: tb/tb_top.sv
// Top of the glyph writer testbench: clock, reset, request and register stimulus and
// the receiver, with the verdict. Depends on tcgw_pkg, tcgw_result_checker and the block.
`timescale 1ns / 1ps

module tb_top;
   import tcgw_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int QUIET_CYCLES = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_operation = 1'b0;
   logic [7:0] req_char_code = '0;
   logic [3:0] req_glyph_row = '0;
   logic [7:0] req_glyph_bits = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic rsp_kind;
   logic [11:0] rsp_pixel_x;
   logic [11:0] rsp_pixel_y;
   logic [7:0] rsp_row_mask;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [11:0] csr_data = '0;

   int mismatch_count;
   int rows_outstanding;
   int gap_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int cycle_count = 0;

   // Only these glyphs are drawn; each has every row loaded first.
   logic [7:0] glyph_codes [4] = '{8'd0, 8'd65, 8'd128, 8'd255};

   text_console_glyph_writer #(
      .GLYPH_COUNT(256),
      .GLYPH_HEIGHT(16)
   ) dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_operation(req_operation),
      .req_char_code(req_char_code), .req_glyph_row(req_glyph_row),
      .req_glyph_bits(req_glyph_bits),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_kind(rsp_kind),
      .rsp_pixel_x(rsp_pixel_x), .rsp_pixel_y(rsp_pixel_y),
      .rsp_row_mask(rsp_row_mask), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   tcgw_result_checker u_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_operation(req_operation),
      .req_char_code(req_char_code), .req_glyph_row(req_glyph_row),
      .req_glyph_bits(req_glyph_bits),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_kind(rsp_kind),
      .rsp_pixel_x(rsp_pixel_x), .rsp_pixel_y(rsp_pixel_y),
      .rsp_row_mask(rsp_row_mask), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatch_count(mismatch_count), .rows_outstanding(rows_outstanding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: a long hold-off, when one is asked for, takes precedence over random stalls.
   always begin
      @(negedge clock);
      if (hold_cycles > 0) begin
         rsp_pop <= 1'b0;
         hold_cycles--;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Entered and left at a falling edge; the push stays high for a following word.
   task automatic send_word(input op_type op, input logic [7:0] code,
                            input logic [3:0] grow, input logic [7:0] gbits);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_operation <= op;
      req_char_code <= code;
      req_glyph_row <= grow;
      req_glyph_bits <= gbits;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic wait_quiet();
      req_push <= 1'b0;
      while (rows_outstanding != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [11:0] width, input logic [11:0] height,
                            input logic en);
      logic [1:0] idx [3];
      logic [11:0] val [3];
      idx = '{CSR_SCREEN_WIDTH, CSR_SCREEN_HEIGHT, CSR_ENABLED};
      val = '{width, height, {11'd0, en}};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      int sel;
      int w;
      int h;
      int words;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every row of each glyph that is drawn is loaded before anything is drawn.
      for (int g = 0; g < 4; g++)
         for (int row = 0; row < 16; row++)
            send_word(OP_LOAD_ROW, glyph_codes[g], 4'(row), 8'($urandom_range(0, 255)));

      // Still disabled after reset: these words must leave no trace.
      send_word(OP_WRITE_CHAR, 8'd65, 4'd0, 8'd0);
      send_word(OP_WRITE_CHAR, NEWLINE_CODE, 4'd15, 8'hFF);
      wait_quiet();

      configure(12'd640, 12'd480, 1'b1);
      send_word(OP_WRITE_CHAR, 8'd0, 4'd0, 8'd0);
      send_word(OP_WRITE_CHAR, 8'd255, 4'd15, 8'hFF);
      send_word(OP_WRITE_CHAR, NEWLINE_CODE, 4'd0, 8'd0);
      send_word(OP_WRITE_CHAR, 8'd65, 4'd0, 8'd0);
      send_word(OP_WRITE_CHAR, 8'd128, 4'd0, 8'd0);
      send_word(OP_LOAD_ROW, 8'd255, 4'd15, 8'hFF);
      send_word(OP_WRITE_CHAR, 8'd255, 4'd0, 8'd0);
      send_word(OP_LOAD_ROW, 8'd0, 4'd0, 8'h00);
      send_word(OP_WRITE_CHAR, 8'd0, 4'd0, 8'd0);
      wait_quiet();

      // Width lowered under the cursor: the glyph is still drawn, then the line breaks.
      configure(12'd8, 12'd480, 1'b1);
      send_word(OP_WRITE_CHAR, 8'd65, 4'd0, 8'd0);
      send_word(OP_WRITE_CHAR, NEWLINE_CODE, 4'd0, 8'd0);
      send_word(OP_WRITE_CHAR, NEWLINE_CODE, 4'd0, 8'd0);
      wait_quiet();

      // Height lowered under the cursor sends it home; with so small a height
      // every line break scrolls.
      configure(12'd640, 12'd32, 1'b1);
      send_word(OP_WRITE_CHAR, 8'd128, 4'd0, 8'd0);
      send_word(OP_WRITE_CHAR, NEWLINE_CODE, 4'd0, 8'd0);
      wait_quiet();

      configure(12'd4095, 12'd4095, 1'b1);
      send_word(OP_WRITE_CHAR, 8'd255, 4'd0, 8'd0);
      send_word(OP_WRITE_CHAR, NEWLINE_CODE, 4'd0, 8'd0);
      wait_quiet();

      // Narrowest and lowest screen: every glyph wraps and scrolls.
      configure(12'd8, 12'd32, 1'b1);
      send_word(OP_WRITE_CHAR, 8'd0, 4'd0, 8'd0);
      send_word(OP_WRITE_CHAR, 8'd65, 4'd0, 8'd0);
      wait_quiet();

      for (int p = 0; p < 8; p++) begin
         sel = $urandom_range(0, 3);
         w = (sel == 0) ? $urandom_range(8, 64) :
             (sel == 3) ? $urandom_range(8, 4095) : $urandom_range(65, 700);
         sel = $urandom_range(0, 3);
         h = (sel < 2) ? $urandom_range(32, 120) :
             (sel == 2) ? $urandom_range(121, 500) : $urandom_range(32, 4095);
         configure(12'(w), 12'(h), p != 5);
         case (p % 4)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 77; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 77; end
            default: begin gap_pct = 20; stall_pct = 20; end
         endcase
         // The receiver holds off long enough for the block to fill and refuse words.
         if (p == 4) hold_cycles = 400;
         words = (p == 5) ? 10 : 20;
         for (int n = 0; n < words; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 12)
               send_word(OP_LOAD_ROW, 8'($urandom_range(0, 255)),
                         4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            else if (sel < 32)
               send_word(OP_WRITE_CHAR, NEWLINE_CODE, 4'($urandom_range(0, 15)),
                         8'($urandom_range(0, 255)));
            else
               send_word(OP_WRITE_CHAR, glyph_codes[$urandom_range(0, 3)],
                         4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
         end
         wait_quiet();
      end

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
